// ===== hw/rtl/afs_pkg.sv =====
// Shared types, constants and stage records for the ADC frame scaler.
package afs_pkg;

    // Frame layout
    localparam int unsigned CELL_CHANNELS = 15;
    localparam int unsigned FRAME_WORDS   = 20;

    // Field widths
    localparam int unsigned SLOT_W  = 5;
    localparam int unsigned RAW_W   = 16;
    localparam int unsigned CELL_W  = 14;
    localparam int unsigned GAIN_W  = 9;
    localparam int unsigned VALUE_W = 17;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SER_W   = 4;

    // Gain base in microvolts per count
    localparam logic [GAIN_W-1:0] GAIN_BASE = GAIN_W'(365);

    // Product of code and gain, pack product carries the extra factor of four
    localparam int unsigned PROD_W = 27;

    // Divide by 1000: multiply by ceil(2^37 / 1000), take bits from 37 up.
    // Exact for every dividend below 2^27.
    localparam int unsigned RECIP_W     = 28;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(137438954);
    localparam int unsigned RECIP_SHIFT = 37;
    localparam int unsigned WIDE_W      = PROD_W + RECIP_W;

    // Clamp limits
    localparam logic [VALUE_W-1:0] CELL_TOP = VALUE_W'(65535);
    localparam logic [VALUE_W-1:0] PACK_TOP = VALUE_W'(100000);

    typedef enum logic [1:0] {
        KIND_CELL = 2'd0,
        KIND_PACK = 2'd1,
        KIND_TEMP = 2'd2,
        KIND_CURR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_GAIN_ONE = 2'd0,
        CFG_GAIN_TWO = 2'd1,
        CFG_OFFSET   = 2'd2,
        CFG_SERIES   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] gain_one;
        logic [BYTE_W-1:0] gain_two;
        logic [BYTE_W-1:0] offset;
        logic [SER_W-1:0]  series;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [RAW_W-1:0]  raw;
        logic [PROD_W-1:0] prod;
        logic [BYTE_W-1:0] offset;
    } t_s1;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [RAW_W-1:0]  raw;
        logic [WIDE_W-1:0] wide;
        logic [BYTE_W-1:0] offset;
    } t_s2;

endpackage

// ===== hw/rtl/afs_gain_stage.sv =====
// First stage: decode the channel, form the gain and multiply the code by it.
module afs_gain_stage import afs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [SLOT_W-1:0]   i_channel_index,
    input  logic [RAW_W-1:0]    i_raw_code,
    input  t_cfg                i_cfg,
    output t_s1                 o_s1
);

    t_s1                 r_s1;
    t_s1                 n_s1;
    logic [GAIN_W-1:0]   gain;
    logic [RAW_W-1:0]    operand;
    logic [PROD_W-3:0]   base_prod;
    logic [11:0]         series_prod;

    // Build the next beat
    always_comb begin
        gain = GAIN_BASE + GAIN_W'({i_cfg.gain_one[3:2], 3'b000})
                         + GAIN_W'(i_cfg.gain_two[7:5]);
        series_prod = 12'(i_cfg.offset) * 12'(i_cfg.series);

        n_s1.valid  = i_valid;
        n_s1.slot   = i_channel_index;
        n_s1.raw    = i_raw_code;
        n_s1.offset = i_cfg.offset;
        operand     = i_raw_code;

        if (i_channel_index < SLOT_W'(CELL_CHANNELS)) begin
            n_s1.kind = KIND_CELL;
            operand   = {{(RAW_W-CELL_W){1'b0}}, i_raw_code[CELL_W-1:0]};
        end else if (i_channel_index == SLOT_W'(CELL_CHANNELS)) begin
            n_s1.kind   = KIND_PACK;
            n_s1.offset = series_prod[BYTE_W-1:0];
        end else if (i_channel_index < SLOT_W'(FRAME_WORDS - 1)) begin
            n_s1.kind = KIND_TEMP;
        end else begin
            n_s1.kind = KIND_CURR;
        end

        base_prod = (PROD_W-2)'(operand) * (PROD_W-2)'(gain);
        // Pack words scale by four
        if (n_s1.kind == KIND_PACK) begin
            n_s1.prod = {base_prod, 2'b00};
        end else begin
            n_s1.prod = {2'b00, base_prod};
        end
    end

    // Hold the beat; only valid needs reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.kind   <= n_s1.kind;
        r_s1.slot   <= n_s1.slot;
        r_s1.raw    <= n_s1.raw;
        r_s1.prod   <= n_s1.prod;
        r_s1.offset <= n_s1.offset;
    end

    assign o_s1 = r_s1;

endmodule

// ===== hw/rtl/afs_recip_stage.sv =====
// Second stage: multiply the product by the reciprocal of 1000.
module afs_recip_stage import afs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_s1   i_s1,
    output t_s2   o_s2
);

    t_s2                 r_s2;
    logic [WIDE_W-1:0]   n_wide;

    assign n_wide = WIDE_W'(i_s1.prod) * WIDE_W'(RECIP_M);

    // Advance the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= i_s1.valid;
        end
        r_s2.kind   <= i_s1.kind;
        r_s2.slot   <= i_s1.slot;
        r_s2.raw    <= i_s1.raw;
        r_s2.wide   <= n_wide;
        r_s2.offset <= i_s1.offset;
    end

    assign o_s2 = r_s2;

endmodule

// ===== hw/rtl/afs_clamp_stage.sv =====
// Third stage: clamp quotient plus offset for voltages, else raw; register it.
module afs_clamp_stage import afs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_s2                 i_s2,
    output logic                o_valid,
    output t_kind               o_kind,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [VALUE_W-1:0]  o_value,
    output logic                o_clamped
);

    logic                r_valid;
    t_kind               r_kind;
    logic [SLOT_W-1:0]   r_slot;
    logic [VALUE_W-1:0]  r_value;
    logic                r_clamped;
    logic [VALUE_W-1:0]  n_value;
    logic                n_clamped;
    logic [VALUE_W-1:0]  quot;
    logic [VALUE_W-1:0]  top;
    logic signed [VALUE_W+1:0] sum;

    // Quotient fits 17 bits for every code and gain
    assign quot = i_s2.wide[RECIP_SHIFT +: VALUE_W];
    assign sum  = $signed({2'b00, quot})
                + $signed({{(VALUE_W+2-BYTE_W){i_s2.offset[BYTE_W-1]}}, i_s2.offset});
    assign top  = (i_s2.kind == KIND_PACK) ? PACK_TOP : CELL_TOP;

    // Select value per channel kind, clamp voltages
    always_comb begin
        n_value   = '0;
        n_clamped = 1'b0;
        case (i_s2.kind)
            KIND_CELL, KIND_PACK: begin
                if (sum < 0) begin
                    n_clamped = 1'b1;
                end else if (sum > $signed({2'b00, top})) begin
                    n_value   = top;
                    n_clamped = 1'b1;
                end else begin
                    n_value   = sum[VALUE_W-1:0];
                end
            end
            KIND_TEMP: n_value = VALUE_W'(i_s2.raw[CELL_W-1:0]);
            default:   n_value = VALUE_W'(i_s2.raw);
        endcase
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s2.valid;
        end
        r_kind    <= i_s2.kind;
        r_slot    <= i_s2.slot;
        r_value   <= n_value;
        r_clamped <= n_clamped;
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_slot    = r_slot;
    assign o_value   = r_value;
    assign o_clamped = r_clamped;

endmodule

// ===== hw/rtl/afe_adc_frame_scaler.sv =====
// Top level of the ADC frame scaler: configuration registers and three-stage pipeline.
//
// Usage:
//   Pulse i_start with i_channel_index and i_raw_code to hand in one ADC word.
//   o_busy is always low, so a word is taken on every cycle that i_start is high.
//   Each word yields one result at the end of the pipeline: o_result_valid is high for
//   exactly one cycle with o_channel_kind, o_channel_slot, o_scaled_value and
//   o_was_clamped. Results leave in the order the words came in.
//   Throughput is one word per cycle; latency is set by the three register
//   stages: gain multiply, reciprocal multiply for the divide by 1000, and the
//   offset add with clamp.
//   The receiver cannot stall: it must take every result in its cycle.
//   Configuration: i_cfg_wr_en with i_cfg_index and i_cfg_wr_data writes gain
//   trim one, gain trim two, offset byte and series count (indexes 0 to 3).
//   Write only while no word is in flight.
//   Synchronous reset (i_rst_n low) empties the pipeline, clears the gain and
//   offset registers and sets series count to 15.
module afe_adc_frame_scaler import afs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [SLOT_W-1:0]   i_channel_index,
    input  logic [RAW_W-1:0]    i_raw_code,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [BYTE_W-1:0]   i_cfg_wr_data,
    output logic                o_result_valid,
    output logic [1:0]          o_channel_kind,
    output logic [SLOT_W-1:0]   o_channel_slot,
    output logic [VALUE_W-1:0]  o_scaled_value,
    output logic                o_was_clamped
);

    t_cfg   r_cfg;
    t_s1    s1;
    t_s2    s2;
    t_kind  kind;
    logic   accept;

    // The pipeline takes a beat every cycle
    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_one <= '0;
            r_cfg.gain_two <= '0;
            r_cfg.offset   <= '0;
            r_cfg.series   <= SER_W'(15);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_ONE: r_cfg.gain_one <= i_cfg_wr_data;
                CFG_GAIN_TWO: r_cfg.gain_two <= i_cfg_wr_data;
                CFG_OFFSET:   r_cfg.offset   <= i_cfg_wr_data;
                CFG_SERIES:   r_cfg.series   <= i_cfg_wr_data[SER_W-1:0];
                default:      r_cfg.series   <= r_cfg.series;
            endcase
        end
    end

    afs_gain_stage u_gain (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (accept),
        .i_channel_index (i_channel_index),
        .i_raw_code      (i_raw_code),
        .i_cfg           (r_cfg),
        .o_s1            (s1)
    );

    afs_recip_stage u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    afs_clamp_stage u_clamp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s2      (s2),
        .o_valid   (o_result_valid),
        .o_kind    (kind),
        .o_slot    (o_channel_slot),
        .o_value   (o_scaled_value),
        .o_clamped (o_was_clamped)
    );

    assign o_channel_kind = kind;

endmodule
